@@ design/u8e_pkg.sv @@
// Shared types and constants for the UTF-32 to UTF-8 encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package u8e_pkg;

  localparam int unsigned MAX_ITEMS_DEFAULT = 65536;

  localparam int unsigned SIZE_W  = 19;
  localparam int unsigned INDEX_W = 17;

  // configuration register indexes
  localparam logic [1:0] CFG_OUT_CAPACITY    = 2'd0;
  localparam logic [1:0] CFG_COUNT_WHEN_FULL = 2'd1;
  localparam logic [1:0] CFG_ZERO_TERMINATED = 2'd2;
  localparam logic [1:0] CFG_SWAP_BYTES      = 2'd3;

  typedef enum logic [1:0] {
    K_DATA    = 2'd0,
    K_DONE    = 2'd1,
    K_SMALL   = 2'd2,
    K_INVALID = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_WRITING  = 3'b001,
    PH_COUNTING = 3'b010,
    PH_FINISHED = 3'b100
  } phase_t;

  typedef struct packed {
    phase_t              phase;
    logic [SIZE_W-1:0]   bytes_written;
    logic [INDEX_W-1:0]  item_index;
    logic [SIZE_W-1:0]   required_total;
    logic [INDEX_W-1:0]  resume_index;
  } enc_state_t;

  // results one item causes: up to four data bytes, then an optional status
  typedef struct packed {
    logic [2:0]          n_data;
    logic [3:0][7:0]     bytes;
    logic                trailer;
    kind_t               tkind;
    logic [SIZE_W-1:0]   tsize;
    logic [INDEX_W-1:0]  tpos;
  } res_plan_t;

endpackage

`default_nettype wire

@@ design/u8e_plan.sv @@
// Per-item decision logic: validity, UTF-8 bytes, capacity check, next state.
// Depends on u8e_pkg.
`default_nettype none

module u8e_plan import u8e_pkg::*; #(
  parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEFAULT
) (
  input  logic [31:0]        cp,
  input  logic               term,
  input  logic [SIZE_W-1:0]  out_capacity,
  input  logic               count_when_full,
  input  enc_state_t         st,
  output enc_state_t         st_next,
  output res_plan_t          plan
);

  localparam longint SizeBound  = longint'(MAX_ITEMS) * 64'd4;
  localparam longint IndexBound = longint'(MAX_ITEMS);
  localparam logic [SIZE_W:0]  SIZE_CAP  =
    (SIZE_W+1)'((SizeBound < 64'h7FFFF) ? SizeBound : 64'h7FFFF);
  localparam logic [INDEX_W:0] INDEX_CAP =
    (INDEX_W+1)'((IndexBound < 64'h1FFFF) ? IndexBound : 64'h1FFFF);

  function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W:0] v);
    return (v < SIZE_CAP) ? v[SIZE_W-1:0] : SIZE_CAP[SIZE_W-1:0];
  endfunction

  logic               invalid;
  logic [2:0]         len;
  logic [SIZE_W:0]    bw_sum;
  logic [SIZE_W:0]    bw_sum1;
  logic [SIZE_W:0]    cnt_sum;
  logic [INDEX_W:0]   idx_inc;
  logic [INDEX_W-1:0] idx_sat;
  logic               fits;
  logic [3:0][7:0]    enc;

  assign invalid = (cp > 32'h0010_FFFF) || ((cp >= 32'h0000_D800) && (cp <= 32'h0000_DFFF));

  always_comb begin
    if (cp < 32'h80) begin
      len = 3'd1;
    end else if (cp < 32'h800) begin
      len = 3'd2;
    end else if (cp <= 32'hFFFF) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
  end

  always_comb begin
    enc = '0;
    unique case (len)
      3'd1: begin
        enc[0] = cp[7:0];
      end
      3'd2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3'd3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
  end

  assign bw_sum  = {1'b0, st.bytes_written} + (SIZE_W+1)'(len);
  assign bw_sum1 = {1'b0, st.bytes_written} + (SIZE_W+1)'(len) + (SIZE_W+1)'(1);
  assign cnt_sum = {1'b0, st.required_total} + (SIZE_W+1)'(len);
  assign idx_inc = {1'b0, st.item_index} + (INDEX_W+1)'(1);
  assign idx_sat = (idx_inc < INDEX_CAP) ? idx_inc[INDEX_W-1:0] : INDEX_CAP[INDEX_W-1:0];
  assign fits    = (bw_sum <= {1'b0, out_capacity});

  always_comb begin
    st_next      = st;
    plan         = '0;
    plan.tkind   = K_DATA;
    plan.bytes   = enc;
    unique case (st.phase) inside
      PH_WRITING, PH_COUNTING: begin
        if (invalid) begin
          plan.trailer  = 1'b1;
          plan.tkind    = K_INVALID;
          plan.tpos     = st.item_index;
          st_next.phase = PH_FINISHED;
        end else if (st.phase == PH_COUNTING) begin
          st_next.required_total = sat_size(cnt_sum);
          st_next.item_index     = idx_sat;
          if (term) begin
            plan.trailer  = 1'b1;
            plan.tkind    = K_SMALL;
            plan.tsize    = sat_size(cnt_sum);
            plan.tpos     = st.resume_index;
            st_next.phase = PH_FINISHED;
          end
        end else if (!fits) begin
          if (!count_when_full && (out_capacity != '0)) begin
            plan.trailer  = 1'b1;
            plan.tkind    = K_SMALL;
            plan.tsize    = sat_size(bw_sum);
            plan.tpos     = st.item_index;
            st_next.phase = PH_FINISHED;
          end else begin
            st_next.required_total = sat_size(bw_sum);
            st_next.resume_index   = st.item_index;
            st_next.item_index     = idx_sat;
            st_next.phase          = PH_COUNTING;
            if (term) begin
              plan.trailer  = 1'b1;
              plan.tkind    = K_SMALL;
              plan.tsize    = sat_size(bw_sum);
              plan.tpos     = st.item_index;
              st_next.phase = PH_FINISHED;
            end
          end
        end else begin
          plan.n_data           = len;
          st_next.bytes_written = bw_sum[SIZE_W-1:0];
          st_next.item_index    = idx_sat;
          if (term) begin
            plan.trailer  = 1'b1;
            plan.tkind    = K_DONE;
            plan.tsize    = sat_size(bw_sum);
            plan.tpos     = idx_sat;
            st_next.phase = PH_FINISHED;
          end else if (bw_sum[SIZE_W-1:0] == out_capacity) begin
            if (!count_when_full) begin
              plan.trailer  = 1'b1;
              plan.tkind    = K_SMALL;
              plan.tsize    = sat_size(bw_sum1);
              plan.tpos     = idx_sat;
              st_next.phase = PH_FINISHED;
            end else begin
              st_next.required_total = sat_size(bw_sum);
              st_next.resume_index   = idx_sat;
              st_next.phase          = PH_COUNTING;
            end
          end
        end
      end
      default: begin
        // finished: item is dropped, no results
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/u8e_emit.sv @@
// Result serializer: holds one item's results and hands them out one a cycle while out_stall is low.
// Depends on u8e_pkg.
`default_nettype none

module u8e_emit import u8e_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  res_plan_t          plan_in,
  output logic               ready,
  output logic               out_valid,
  input  logic               out_stall,
  output kind_t              res_kind,
  output logic [7:0]         res_byte,
  output logic [SIZE_W-1:0]  res_size,
  output logic [INDEX_W-1:0] res_pos,
  output logic               res_last
);

  logic       busy;
  res_plan_t  plan;
  logic [2:0] sel;
  logic       is_data;

  assign is_data  = (sel < plan.n_data);
  assign res_last = is_data ? ((3'(sel + 3'd1) == plan.n_data) && !plan.trailer) : 1'b1;
  assign res_kind = is_data ? K_DATA : plan.tkind;
  assign res_byte = is_data ? plan.bytes[sel[1:0]] : 8'd0;
  assign res_size = is_data ? '0 : plan.tsize;
  assign res_pos  = is_data ? '0 : plan.tpos;

  assign out_valid = busy;
  assign ready     = !busy || (!out_stall && res_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      sel  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      sel  <= '0;
    end else if (busy && !out_stall) begin
      if (res_last) begin
        busy <= 1'b0;
      end else begin
        sel <= 3'(sel + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      plan <= plan_in;
    end
  end

endmodule

`default_nettype wire

@@ design/utf32_to_utf8_encoder.sv @@
// Top level of the UTF-32 to UTF-8 encoder: config registers, input stage,
// encoder state. Depends on u8e_pkg, u8e_plan and u8e_emit.
`default_nettype none

// Converts a string of UTF-32 code points, one per input transaction, into
// UTF-8 bytes, one per output transaction, followed by a status transaction
// (done, output too small, or invalid code point) when the string ends. A
// string ends at a zero code point or at an item flagged final_item, per
// zero_terminated; the word may be byte-swapped first (swap_bytes). Output
// bytes count against out_capacity; when a code point does not fit, the block
// either stops with the size it needed or, with count_when_full (or a zero
// capacity), keeps counting and reports the total size the string needs.
// After a status result, further items are taken and dropped until reset.
// Timing: an input transaction lands in an input register, is decided there
// and moves into the result serializer, so the input side takes one item a
// cycle while the serializer has room. The single-byte output port sets the
// sustained rate: an item holds the serializer until all of its results (up
// to 4 data bytes, plus one for a status) have gone out, one per output
// transaction. Items that cause no result (counting past capacity, or after
// the end) flow at one per cycle. Program the configuration registers only
// while the block is idle.
module utf32_to_utf8_encoder import u8e_pkg::*; #(
  parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [SIZE_W-1:0]  cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        code_point,
  input  logic               final_item,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic [7:0]         byte_value,
  output logic [SIZE_W-1:0]  size_value,
  output logic [INDEX_W-1:0] position,
  output logic               run_end
);

  localparam longint IndexBound = longint'(MAX_ITEMS);
  localparam logic [INDEX_W:0] INDEX_CAP =
    (INDEX_W+1)'((IndexBound < 64'h1FFFF) ? IndexBound : 64'h1FFFF);

  // configuration registers
  logic [SIZE_W-1:0] out_capacity;
  logic              count_when_full;
  logic              zero_terminated;
  logic              swap_bytes;

  // input register
  logic        s1_valid;
  logic [31:0] s1_cp;
  logic        s1_term;

  enc_state_t st;
  enc_state_t st_next;
  res_plan_t  plan;

  logic        in_take;
  logic        s1_go;
  logic        s1_done;
  logic        plan_empty;
  logic        emit_ready;
  logic [31:0] cp_in;
  kind_t       res_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity    <= '0;
      count_when_full <= 1'b0;
      zero_terminated <= 1'b1;
      swap_bytes      <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_OUT_CAPACITY:    out_capacity    <= cfg_data;
        CFG_COUNT_WHEN_FULL: count_when_full <= cfg_data[0];
        CFG_ZERO_TERMINATED: zero_terminated <= cfg_data[0];
        CFG_SWAP_BYTES:      swap_bytes      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Swap and resolve the terminator at capture; the user must keep both settings
  // static while a string is in flight, the block itself does not enforce it.
  assign cp_in = swap_bytes ? {code_point[7:0], code_point[15:8],
                               code_point[23:16], code_point[31:24]}
                            : code_point;

  // An item with no results never waits for the serializer.
  assign plan_empty = (plan.n_data == 3'd0) && !plan.trailer;
  assign s1_go      = plan_empty || emit_ready;
  assign s1_done    = s1_valid && s1_go;
  assign in_stall   = s1_valid && !s1_go;
  assign in_take    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cp   <= cp_in;
      s1_term <= zero_terminated ? (cp_in == 32'd0) : final_item;
    end
  end

  // Advance the encoder state as the item leaves the input register; its
  // results are queued in order, so the state may run ahead of the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase          <= PH_WRITING;
      st.bytes_written  <= '0;
      st.item_index     <= '0;
      st.required_total <= '0;
      st.resume_index   <= '0;
    end else if (s1_done) begin
      st <= st_next;
    end
  end

  u8e_plan #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_plan (
    .cp              (s1_cp),
    .term            (s1_term),
    .out_capacity    (out_capacity),
    .count_when_full (count_when_full),
    .st              (st),
    .st_next         (st_next),
    .plan            (plan)
  );

  u8e_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_valid && !plan_empty && emit_ready),
    .plan_in   (plan),
    .ready     (emit_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_kind  (res_kind),
    .res_byte  (byte_value),
    .res_size  (size_value),
    .res_pos   (position),
    .res_last  (run_end)
  );

  assign kind = res_kind;

  // A status result always closes its item's run.
  a_status_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && (res_kind != K_DATA) |-> run_end)
    else $error("status result without run_end");

  // A status result is only queued together with the move to finished.
  a_status_means_finished: assert property (@(posedge clk) disable iff (rst)
    out_valid && (res_kind != K_DATA) |-> (st.phase == PH_FINISHED))
    else $error("status result while string still open");

  // The item counter never passes its saturation bound.
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, st.item_index} <= INDEX_CAP))
    else $error("item index beyond bound");

endmodule

`default_nettype wire
